>>> rtl/core/text_console_writer_unit_assert.svh
// Assertion helpers for the RTL files (included by tcw_dpath.sv).
`ifndef TEXT_CONSOLE_WRITER_UNIT_ASSERT_SVH
`define TEXT_CONSOLE_WRITER_UNIT_ASSERT_SVH

// Same-cycle implication, inactive while reset is asserted.
`define TCW_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("tcw assertion failed");

// Next-cycle implication, inactive while reset is asserted.
`define TCW_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("tcw assertion failed");

`endif

>>> rtl/core/tcw_pkg.sv
package tcw_pkg;

    localparam int COLUMNS = 80;
    localparam int ROWS    = 50;

    localparam int ROW_W   = $clog2(ROWS);
    localparam int COL_W   = $clog2(COLUMNS + 1);
    localparam int CHAR_W  = 8;
    localparam int CELL_W  = CHAR_W + 1;
    localparam int WORD_W  = 32;
    localparam int DEPTH   = ROWS * COLUMNS;
    localparam int ADDR_W  = $clog2(DEPTH);

    localparam logic [WORD_W-1:0] CELL_TAG = 32'h003F_0000;

    localparam logic [CHAR_W-1:0] CH_BS        = 8'd8;
    localparam logic [CHAR_W-1:0] CH_LF        = 8'd10;
    localparam logic [CHAR_W-1:0] CH_CR        = 8'd13;
    localparam logic [CHAR_W-1:0] CH_PRINT_MIN = 8'd32;

    typedef enum logic [1:0] {
        OP_PUT   = 2'd0,
        OP_READ  = 2'd1,
        OP_CLEAR = 2'd2,
        OP_NONE  = 2'd3
    } t_op;

    typedef struct packed {
        logic load;
        logic exec;
        logic place;
        logic sweep;
        logic rd_capture;
        logic finish;
    } t_cmd;

    typedef struct packed {
        logic is_print;
        logic is_read;
        logic row_ready;
        logic sweep_last;
        logic out_free;
    } t_stat;

endpackage

>>> rtl/core/tcw_ram.sv
module tcw_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> rtl/core/tcw_ctrl.sv
module tcw_ctrl import tcw_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_valid,
    input  t_stat i_stat,
    output logic  o_in_stall,
    output t_cmd  o_cmd
);

    typedef enum logic [5:0] {
        S_IDLE   = 6'b000001,
        S_EXEC   = 6'b000010,
        S_PLACE  = 6'b000100,
        S_SWEEP  = 6'b001000,
        S_RWAIT  = 6'b010000,
        S_FINISH = 6'b100000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_EXEC;
                end
            end
            S_EXEC: begin
                o_cmd.exec = 1'b1;
                if (i_stat.is_print) begin
                    n_state = S_PLACE;
                end else if (i_stat.is_read) begin
                    n_state = S_RWAIT;
                end else begin
                    n_state = S_FINISH;
                end
            end
            S_PLACE: begin
                o_cmd.place = 1'b1;
                n_state     = i_stat.row_ready ? S_FINISH : S_SWEEP;
            end
            S_SWEEP: begin
                o_cmd.sweep = 1'b1;
                if (i_stat.sweep_last) begin
                    n_state = S_FINISH;
                end
            end
            S_RWAIT: begin
                o_cmd.rd_capture = 1'b1;
                n_state          = S_FINISH;
            end
            S_FINISH: begin
                if (i_stat.out_free) begin
                    o_cmd.finish = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_stall = (r_state != S_IDLE);

endmodule

>>> rtl/core/tcw_dpath.sv
`include "text_console_writer_unit_assert.svh"

module tcw_dpath import tcw_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_cmd              i_cmd,
    output t_stat             o_stat,
    input  logic [1:0]        i_opcode,
    input  logic [CHAR_W-1:0] i_char_code,
    input  logic [ROW_W-1:0]  i_read_row,
    input  logic [COL_W-1:0]  i_read_col,
    input  logic              i_out_stall,
    output logic              o_out_valid,
    output logic [WORD_W-1:0] o_cell_word,
    output logic [ROW_W-1:0]  o_cursor_row,
    output logic [COL_W-1:0]  o_cursor_col
);

    function automatic logic [ROW_W-1:0] phys_of(input logic [ROW_W-1:0] row,
                                                  input logic [ROW_W-1:0] top);
        logic [ROW_W:0] sum;
        sum = {1'b0, row} + {1'b0, top};
        if (sum >= (ROW_W + 1)'(ROWS)) begin
            sum = sum - (ROW_W + 1)'(ROWS);
        end
        return sum[ROW_W-1:0];
    endfunction

    function automatic logic [ADDR_W-1:0] addr_of(input logic [ROW_W-1:0] phys,
                                                   input logic [COL_W-1:0] col);
        return ADDR_W'(phys) * ADDR_W'(COLUMNS) + ADDR_W'(col);
    endfunction

    // item payload
    t_op               r_op;
    logic [CHAR_W-1:0] r_ch;
    logic [ROW_W-1:0]  r_rr;
    logic [COL_W-1:0]  r_rc;

    // console state; r_row_ok marks rows whose cells have been blanked
    logic [ROW_W-1:0]  r_top,    n_top;
    logic [ROW_W-1:0]  r_wrow,   n_wrow;
    logic [COL_W-1:0]  r_wcol,   n_wcol;
    logic [ROW_W-1:0]  r_srow,   n_srow;
    logic [COL_W-1:0]  r_scol,   n_scol;
    logic [ROWS-1:0]   r_row_ok, n_row_ok;

    logic [COL_W-1:0]  r_x,      n_x;
    logic [COL_W-1:0]  r_sweep,  n_sweep;
    logic              r_rd_ok,  n_rd_ok;
    logic [WORD_W-1:0] r_word,   n_word;

    logic              r_out_valid;
    logic [WORD_W-1:0] r_out_word;
    logic [ROW_W-1:0]  r_out_row;
    logic [COL_W-1:0]  r_out_col;

    logic              ram_we;
    logic [ADDR_W-1:0] ram_waddr;
    logic [CELL_W-1:0] ram_wdata;
    logic              ram_re;
    logic [ADDR_W-1:0] ram_raddr;
    logic [CELL_W-1:0] ram_rdata;

    logic [ROW_W-1:0]  phys_w;
    logic [ROW_W-1:0]  phys_rd;
    logic              rd_in_range;
    logic              row_last;
    logic [ROW_W-1:0]  top_inc;
    logic              do_nl;
    logic              upd_shown;
    logic [COL_W-1:0]  x;

    assign phys_w      = phys_of(r_wrow, r_top);
    assign phys_rd     = phys_of(r_rr, r_top);
    assign rd_in_range = ({1'b0, r_rr} < (ROW_W + 1)'(ROWS)) &&
                         ({1'b0, r_rc} < (COL_W + 1)'(COLUMNS));
    assign row_last    = (r_wrow == ROW_W'(ROWS - 1));
    assign top_inc     = (r_top == ROW_W'(ROWS - 1)) ? '0 : r_top + 1'b1;

    always_comb begin
        n_top     = r_top;
        n_wrow    = r_wrow;
        n_wcol    = r_wcol;
        n_srow    = r_srow;
        n_scol    = r_scol;
        n_row_ok  = r_row_ok;
        n_x       = r_x;
        n_sweep   = r_sweep;
        n_rd_ok   = r_rd_ok;
        n_word    = r_word;
        ram_we    = 1'b0;
        ram_waddr = addr_of(phys_w, r_x);
        ram_wdata = {1'b1, r_ch};
        ram_re    = 1'b0;
        ram_raddr = addr_of(phys_rd, r_rc);
        do_nl     = 1'b0;
        upd_shown = 1'b0;
        x         = r_wcol;

        if (i_cmd.load) begin
            n_word = '0;
        end

        if (i_cmd.exec) begin
            case (r_op)
                OP_PUT: begin
                    if (r_ch >= CH_PRINT_MIN) begin
                        if (r_wcol >= COL_W'(COLUMNS)) begin
                            x     = '0;
                            do_nl = 1'b1;
                        end
                        n_x       = x;
                        n_wcol    = x + 1'b1;
                        upd_shown = 1'b1;
                    end else if (r_ch == CH_CR) begin
                        n_wcol    = '0;
                        upd_shown = 1'b1;
                    end else if (r_ch == CH_BS) begin
                        if (r_wcol != '0) begin
                            n_wcol = r_wcol - 1'b1;
                        end
                        upd_shown = 1'b1;
                    end else if (r_ch == CH_LF) begin
                        n_wcol    = '0;
                        do_nl     = 1'b1;
                        upd_shown = 1'b1;
                    end
                end
                OP_READ: begin
                    ram_re  = rd_in_range;
                    n_rd_ok = rd_in_range && r_row_ok[phys_rd];
                end
                OP_CLEAR: begin
                    n_row_ok = '0;
                    n_top    = '0;
                    n_wrow   = '0;
                    n_wcol   = '0;
                end
                default: begin
                end
            endcase

            if (do_nl) begin
                if (row_last) begin
                    n_row_ok[r_top] = 1'b0;
                    n_top           = top_inc;
                end else begin
                    n_wrow = r_wrow + 1'b1;
                end
            end
            if (upd_shown) begin
                n_srow = n_wrow;
                n_scol = n_wcol;
            end
        end

        if (i_cmd.place) begin
            if (r_row_ok[phys_w]) begin
                ram_we = 1'b1;
            end else begin
                n_sweep = '0;
            end
        end

        // blank a fresh row, dropping the new character into its column
        if (i_cmd.sweep) begin
            ram_we    = 1'b1;
            ram_waddr = addr_of(phys_w, r_sweep);
            ram_wdata = (r_sweep == r_x) ? {1'b1, r_ch} : '0;
            if (o_stat.sweep_last) begin
                n_row_ok[phys_w] = 1'b1;
            end else begin
                n_sweep = r_sweep + 1'b1;
            end
        end

        if (i_cmd.rd_capture) begin
            n_word = (r_rd_ok && ram_rdata[CELL_W-1]) ?
                     (CELL_TAG | WORD_W'(ram_rdata[CHAR_W-1:0])) : '0;
        end
    end

    always_comb begin
        o_stat            = '0;
        o_stat.is_print   = (r_op == OP_PUT) && (r_ch >= CH_PRINT_MIN);
        o_stat.is_read    = (r_op == OP_READ);
        o_stat.row_ready  = r_row_ok[phys_w];
        o_stat.sweep_last = (r_sweep == COL_W'(COLUMNS - 1));
        o_stat.out_free   = !r_out_valid || !i_out_stall;
    end

    tcw_ram #(
        .WIDTH (CELL_W),
        .DEPTH (DEPTH)
    ) u_cells (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_top       <= '0;
            r_wrow      <= '0;
            r_wcol      <= '0;
            r_srow      <= '0;
            r_scol      <= '0;
            r_row_ok    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_top    <= n_top;
            r_wrow   <= n_wrow;
            r_wcol   <= n_wcol;
            r_srow   <= n_srow;
            r_scol   <= n_scol;
            r_row_ok <= n_row_ok;
            if (i_cmd.finish) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op <= t_op'(i_opcode);
            r_ch <= i_char_code;
            r_rr <= i_read_row;
            r_rc <= i_read_col;
        end
        r_x     <= n_x;
        r_sweep <= n_sweep;
        r_rd_ok <= n_rd_ok;
        r_word  <= n_word;
        if (i_cmd.finish) begin
            r_out_word <= r_word;
            r_out_row  <= r_srow;
            r_out_col  <= r_scol;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_cell_word  = r_out_word;
    assign o_cursor_row = r_out_row;
    assign o_cursor_col = r_out_col;

    `TCW_ASSERT_NOW(a_sweep_row_fresh, i_cmd.sweep, !r_row_ok[phys_w])
    `TCW_ASSERT_NOW(a_finish_slot_free, i_cmd.finish, !r_out_valid || !i_out_stall)
    `TCW_ASSERT_NOW(a_cursor_bounds, 1'b1,
                    (r_wcol <= COL_W'(COLUMNS)) && ({1'b0, r_wrow} < (ROW_W + 1)'(ROWS)) &&
                    ({1'b0, r_top} < (ROW_W + 1)'(ROWS)))
    `TCW_ASSERT_NEXT(a_clear_wipes, i_cmd.exec && (r_op == OP_CLEAR),
                     (r_row_ok == '0) && (r_top == '0) && (r_wcol == '0))

endmodule

>>> rtl/core/text_console_writer_unit.sv
// Text console writer: 80 x 50 character screen with a write cursor.
// Input channel (i_in_valid / o_in_stall) carries one operation per
// transaction: put character, read cell, clear screen and home cursor, or no-op.
// Output channel (o_out_valid / i_out_stall) returns exactly one result per
// input transaction: the cell word for a read (0 otherwise) and the
// displayed cursor position.
// Items are handled one at a time by the control sequencer. The result is
// registered on leaving S_FINISH, reached through S_EXEC for control codes,
// clear and no-op, through S_EXEC and S_RWAIT for a read (registered cell RAM
// read) and through S_EXEC and S_PLACE for a printable put. A printable put
// that lands on a row not yet blanked since reset, clear or scroll also
// sweeps that row in S_SWEEP through the cell RAM write port, one column per
// cycle, before S_FINISH. A new item is taken in S_IDLE after S_FINISH.
// Reset clears the cursor, the scroll offset and the per-row blank flags at
// once; no clearing pass runs and the cell RAM content is ignored until a
// row is rewritten. A stalled result stays in the output register while the
// next transaction is processed; that one waits to finish until the
// output register is free.
module text_console_writer_unit import tcw_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  logic [1:0]        i_opcode,
    input  logic [CHAR_W-1:0] i_char_code,
    input  logic [ROW_W-1:0]  i_read_row,
    input  logic [COL_W-1:0]  i_read_col,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output logic [WORD_W-1:0] o_cell_word,
    output logic [ROW_W-1:0]  o_cursor_row,
    output logic [COL_W-1:0]  o_cursor_col
);

    t_cmd  cmd;
    t_stat stat;

    tcw_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_stat     (stat),
        .o_in_stall (o_in_stall),
        .o_cmd      (cmd)
    );

    tcw_dpath u_dpath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .o_stat       (stat),
        .i_opcode     (i_opcode),
        .i_char_code  (i_char_code),
        .i_read_row   (i_read_row),
        .i_read_col   (i_read_col),
        .i_out_stall  (i_out_stall),
        .o_out_valid  (o_out_valid),
        .o_cell_word  (o_cell_word),
        .o_cursor_row (o_cursor_row),
        .o_cursor_col (o_cursor_col)
    );

endmodule

>>> dv/tb_top.sv
`timescale 1ns / 100ps

package tb_console_pkg;
    import tcw_pkg::*;

    typedef struct packed {
        logic [WORD_W-1:0] cell_word;
        logic [ROW_W-1:0]  cursor_row;
        logic [COL_W-1:0]  cursor_col;
    } t_console_reply;

    class console_scoreboard;
        logic [CELL_W-1:0] cells [DEPTH];
        int unsigned       top_off;
        int unsigned       wr_row;
        int unsigned       wr_col;
        int unsigned       shown_row;
        int unsigned       shown_col;
        t_console_reply    replies_due [$];
        int                errors;

        function new();
            blank_screen();
            shown_row = 0;
            shown_col = 0;
            errors    = 0;
        endfunction

        function void blank_screen();
            foreach (cells[i]) cells[i] = '0;
            top_off = 0;
            wr_row  = 0;
            wr_col  = 0;
        endfunction

        function int unsigned cell_addr(int unsigned row, int unsigned col);
            return ((row + top_off) % ROWS) * COLUMNS + col;
        endfunction

        function void advance_row();
            wr_row++;
            if (wr_row >= ROWS) begin
                for (int c = 0; c < COLUMNS; c++) cells[top_off * COLUMNS + c] = '0;
                top_off = (top_off + 1) % ROWS;
                wr_row  = ROWS - 1;
            end
        endfunction

        function void write_char(logic [CHAR_W-1:0] ch);
            int unsigned x;
            if (ch < CH_PRINT_MIN) begin
                case (ch)
                    CH_CR: wr_col = 0;
                    CH_BS: if (wr_col > 0) wr_col--;
                    CH_LF: begin
                        wr_col = 0;
                        advance_row();
                    end
                    default: return;
                endcase
                shown_row = wr_row;
                shown_col = wr_col;
                return;
            end
            x = wr_col;
            if (x >= COLUMNS) begin
                x = 0;
                advance_row();
            end
            wr_col = x + 1;
            cells[cell_addr(wr_row, x)] = {1'b1, ch};
            shown_row = wr_row;
            shown_col = x + 1;
        endfunction

        function void note_input(logic [1:0] op, logic [CHAR_W-1:0] ch,
                                 logic [ROW_W-1:0] rr, logic [COL_W-1:0] rc);
            t_console_reply r;
            logic [CELL_W-1:0] c;
            r.cell_word = '0;
            case (t_op'(op))
                OP_PUT:   write_char(ch);
                OP_READ: begin
                    if (rr < ROWS && rc < COLUMNS) begin
                        c = cells[cell_addr(rr, rc)];
                        if (c[CHAR_W]) r.cell_word = CELL_TAG | WORD_W'(c[CHAR_W-1:0]);
                    end
                end
                OP_CLEAR: blank_screen();
                default: ;
            endcase
            r.cursor_row = ROW_W'(shown_row);
            r.cursor_col = COL_W'(shown_col);
            replies_due.push_back(r);
        endfunction

        task report_mismatch(string what, longint got, longint want);
            $display("tb: mismatch %s: got %0h want %0h", what, got, want);
            errors++;
        endtask

        task check_result(logic [WORD_W-1:0] word, logic [ROW_W-1:0] row,
                          logic [COL_W-1:0] col);
            t_console_reply w;
            if (replies_due.size() == 0) begin
                report_mismatch("unexpected transaction", word, 0);
                return;
            end
            w = replies_due.pop_front();
            if (word !== w.cell_word)  report_mismatch("cell_word", word, w.cell_word);
            if (row  !== w.cursor_row) report_mismatch("cursor_row", row, w.cursor_row);
            if (col  !== w.cursor_col) report_mismatch("cursor_col", col, w.cursor_col);
        endtask
    endclass
endpackage

module tb_top;
    import tcw_pkg::*;
    import tb_console_pkg::*;

    localparam int IDLE_LIMIT   = 5000;
    localparam int HOLD_CYCLES  = 400;
    localparam int PHASE_ITEMS  = 420;

    logic              i_clk;
    logic              i_rst_n;
    logic              i_in_valid;
    logic              o_in_stall;
    logic [1:0]        i_opcode;
    logic [CHAR_W-1:0] i_char_code;
    logic [ROW_W-1:0]  i_read_row;
    logic [COL_W-1:0]  i_read_col;
    logic              o_out_valid;
    logic              i_out_stall;
    logic [WORD_W-1:0] o_cell_word;
    logic [ROW_W-1:0]  o_cursor_row;
    logic [COL_W-1:0]  o_cursor_col;

    console_scoreboard sb = new();

    int gap_pct;
    int stall_pct;
    int hold_requests;
    int items_sent;
    int idle_cycles;

    text_console_writer_unit dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_opcode     (i_opcode),
        .i_char_code  (i_char_code),
        .i_read_row   (i_read_row),
        .i_read_col   (i_read_col),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_cell_word  (o_cell_word),
        .o_cursor_row (o_cursor_row),
        .o_cursor_col (o_cursor_col)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // receiver side; long hold-off counted here
    initial begin
        int hold_seen;
        int hold_left;
        hold_seen   = 0;
        hold_left   = 0;
        i_out_stall = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_requests != hold_seen) begin
                hold_seen = hold_requests;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_out_stall <= 1'b1;
            end else begin
                i_out_stall <= ($urandom_range(99) < stall_pct);
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_in_valid && !o_in_stall)
                sb.note_input(i_opcode, i_char_code, i_read_row, i_read_col);
            if (o_out_valid && !i_out_stall)
                sb.check_result(o_cell_word, o_cursor_row, o_cursor_col);
        end
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    task automatic send_item(t_op op, logic [CHAR_W-1:0] ch,
                             logic [ROW_W-1:0] rr, logic [COL_W-1:0] rc);
        while ($urandom_range(99) < gap_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_opcode    <= op;
        i_char_code <= ch;
        i_read_row  <= rr;
        i_read_col  <= rc;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        if (op != OP_NONE) items_sent++;
    endtask

    task automatic send_put(logic [CHAR_W-1:0] ch);
        send_item(OP_PUT, ch, ROW_W'($urandom), COL_W'($urandom));
    endtask

    task automatic send_read(int rr, int rc);
        send_item(OP_READ, CHAR_W'($urandom), ROW_W'(rr), COL_W'(rc));
    endtask

    task automatic random_sequence();
        int kind;
        int len;
        int r;
        int c;
        kind = $urandom_range(99);
        if (kind < 40) begin
            // line of text, sometimes long enough to wrap
            len = ($urandom_range(9) == 0) ? $urandom_range(70, 170) : $urandom_range(1, 30);
            repeat (len) send_put(CHAR_W'($urandom_range(32, 255)));
            case ($urandom_range(3))
                0: send_put(CH_LF);
                1: begin
                    send_put(CH_CR);
                    send_put(CH_LF);
                end
                2: send_put(CH_CR);
                default: ;
            endcase
        end else if (kind < 55) begin
            repeat ($urandom_range(1, 60)) send_put(CH_LF);
        end else if (kind < 77) begin
            repeat ($urandom_range(1, 5)) begin
                case ($urandom_range(9))
                    0, 1, 2, 3: begin
                        r = sb.wr_row;
                        c = (sb.wr_col > 0 && $urandom_range(1)) ? sb.wr_col - 1
                                                                : $urandom_range(0, 79);
                    end
                    4, 5: begin
                        r = (sb.wr_row > 0) ? sb.wr_row - 1 : 0;
                        c = $urandom_range(0, 79);
                    end
                    6, 7, 8: begin
                        r = $urandom_range(0, 49);
                        c = $urandom_range(0, 79);
                    end
                    default: begin
                        r = $urandom_range(0, 63);
                        c = $urandom_range(0, 127);
                    end
                endcase
                send_read(r, c);
            end
        end else if (kind < 90) begin
            repeat ($urandom_range(1, 12)) begin
                case ($urandom_range(4))
                    0, 1: send_put(CH_BS);
                    2: send_put(CH_CR);
                    3: send_put(CHAR_W'($urandom_range(0, 31)));
                    default: send_put(CHAR_W'($urandom_range(32, 255)));
                endcase
            end
            if ($urandom_range(5) == 0) repeat ($urandom_range(40, 90)) send_put(CH_BS);
        end else if (kind < 93) begin
            send_item(OP_CLEAR, CHAR_W'($urandom), ROW_W'($urandom), COL_W'($urandom));
        end else begin
            send_item(t_op'($urandom_range(0, 3)), CHAR_W'($urandom),
                      ROW_W'($urandom), COL_W'($urandom));
        end
    endtask

    initial begin
        int phase_end;
        int gaps [4];
        int stalls [4];
        gaps   = '{0, 82, 0, 25};
        stalls = '{0, 0, 82, 25};
        i_rst_n       = 1'b0;
        i_in_valid    = 1'b0;
        i_opcode      = OP_PUT;
        i_char_code   = '0;
        i_read_row    = '0;
        i_read_col    = '0;
        gap_pct       = 0;
        stall_pct     = 0;
        hold_requests = 0;
        items_sent    = 0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed
        send_read(0, 0);
        send_put(8'd65);
        send_put(8'd255);
        send_put(CH_PRINT_MIN);
        send_put(8'd128);
        send_read(0, 0);
        send_read(0, 1);
        send_read(0, 3);
        send_put(CH_BS);
        send_put(CH_BS);
        send_put(CH_BS);
        send_put(CH_BS);
        send_put(CH_BS);
        send_put(8'd0);
        send_put(8'd31);
        send_put(CH_LF);
        send_put(8'd127);
        send_put(CH_CR);
        send_item(OP_NONE, 8'hFF, 6'h3F, 7'h7F);
        send_read(63, 127);
        send_read(49, 79);
        send_read(0, 80);
        send_read(50, 0);
        send_item(OP_CLEAR, 8'hFF, 6'h3F, 7'h7F);
        send_read(1, 0);

        phase_end = items_sent;
        for (int p = 0; p < 4; p++) begin
            gap_pct   = gaps[p];
            stall_pct <= stalls[p];
            phase_end += PHASE_ITEMS;
            while (items_sent < phase_end) begin
                if (p == 0 && hold_requests == 0 && items_sent > phase_end - PHASE_ITEMS / 2)
                    hold_requests <= 1;
                random_sequence();
            end
        end
        i_in_valid <= 1'b0;

        while (sb.replies_due.size() != 0) @(posedge i_clk);
        repeat (120) @(posedge i_clk);
        if (sb.errors == 0 && sb.replies_due.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end
endmodule

>>> files.f
+incdir+rtl/core
rtl/core/tcw_pkg.sv
rtl/core/tcw_ram.sv
rtl/core/tcw_ctrl.sv
rtl/core/tcw_dpath.sv
rtl/core/text_console_writer_unit.sv
dv/tb_top.sv
